>>> rtl/core/rxrb_pkg.sv
// Shared constants, types and helpers of the receive ring buffer.
package rxrb_pkg;

  localparam int unsigned DEPTH  = 256;
  localparam int unsigned ADDR_W = $clog2(DEPTH);
  localparam int unsigned CNT_W  = ADDR_W + 1;

  localparam logic [7:0] DELIM_RST = 8'd10;

  typedef enum logic [2:0] {
    KIND_PUSH    = 3'd0,
    KIND_POP     = 3'd1,
    KIND_CLEAR   = 3'd2,
    KIND_OVERRUN = 3'd3,
    KIND_STATUS  = 3'd4
  } kind_e;

  typedef struct packed {
    logic [7:0] read_data;
    logic       read_valid;
    logic [7:0] bytes_waiting;
    logic [7:0] line_length;
    logic       overflow;
  } res_t;

  function automatic logic [ADDR_W-1:0] advance(input logic [ADDR_W-1:0] idx);
    logic [ADDR_W-1:0] nxt;
    if (idx == ADDR_W'(DEPTH - 1)) begin
      nxt = '0;
    end else begin
      nxt = idx + ADDR_W'(1);
    end
    return nxt;
  endfunction

  function automatic logic [7:0] sat8(input logic [CNT_W-1:0] v);
    logic [CNT_W+7:0] w;
    logic [7:0]       r;
    w = {8'b0, v};
    if (w > (CNT_W + 8)'(255)) begin
      r = 8'hFF;
    end else begin
      r = w[7:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/rxrb_in_if.sv
// Input channel: command kind and received byte.
interface rxrb_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] kind;
  logic [7:0] rx_byte;

  modport source (output valid, output kind, output rx_byte, input ready);
  modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

>>> rtl/core/rxrb_out_if.sv
// Output channel: status result of one item.
interface rxrb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       read_valid;
  logic [7:0] bytes_waiting;
  logic [7:0] line_length;
  logic       overflow;

  modport source (output valid, output read_data, output read_valid,
                  output bytes_waiting, output line_length, output overflow,
                  input ready);
  modport sink   (input valid, input read_data, input read_valid,
                  input bytes_waiting, input line_length, input overflow,
                  output ready);
endinterface

>>> rtl/core/rxrb_core.sv
// Ring pointers, byte store and the sequencer that runs the delimiter scan.
module rxrb_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic [2:0]          kind_i,
  input  logic [7:0]          rx_byte_i,
  input  logic [7:0]          delim_i,
  input  logic                res_ready_i,
  output logic                idle_o,
  output logic                res_valid_o,
  output rxrb_pkg::res_t      res_o
);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_EXEC = 5'b00010,
    S_POP  = 5'b00100,
    S_SCAN = 5'b01000,
    S_PUT  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  logic [rxrb_pkg::ADDR_W-1:0] rd_idx_q, rd_idx_d;
  logic [rxrb_pkg::ADDR_W-1:0] wr_idx_q, wr_idx_d;
  logic [rxrb_pkg::ADDR_W-1:0] scan_idx_q, scan_idx_d;
  logic [rxrb_pkg::ADDR_W-1:0] n_q, n_d;
  logic [rxrb_pkg::ADDR_W-1:0] len_q, len_d;
  logic                        ovf_q, ovf_d;
  logic                        pend_q, pend_d;
  logic [2:0]                  kind_q, kind_d;
  logic [7:0]                  byte_q, byte_d;
  logic [7:0]                  rdata_q, rdata_d;
  logic                        rvalid_q, rvalid_d;

  logic [7:0]                  mem_q [rxrb_pkg::DEPTH];
  logic [7:0]                  mem_rdata_q;
  logic [rxrb_pkg::ADDR_W-1:0] mem_raddr;
  logic                        mem_we;
  logic [rxrb_pkg::CNT_W-1:0]  held;

  always_comb begin
    state_d    = state_q;
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    scan_idx_d = scan_idx_q;
    n_d        = n_q;
    len_d      = len_q;
    ovf_d      = ovf_q;
    pend_d     = pend_q;
    kind_d     = kind_q;
    byte_d     = byte_q;
    rdata_d    = rdata_q;
    rvalid_d   = rvalid_q;
    mem_raddr  = rd_idx_q;
    mem_we     = 1'b0;
    res_valid_o = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (start_i) begin
          kind_d   = kind_i;
          byte_d   = rx_byte_i;
          rdata_d  = '0;
          rvalid_d = 1'b0;
          state_d  = S_EXEC;
        end
      end
      S_EXEC: begin
        n_d        = '0;
        pend_d     = 1'b0;
        scan_idx_d = rd_idx_q;
        state_d    = S_SCAN;
        unique case (kind_q)
          rxrb_pkg::KIND_PUSH: begin
            if (rxrb_pkg::advance(wr_idx_q) == rd_idx_q) begin
              ovf_d = 1'b1;
            end else begin
              mem_we   = 1'b1;
              wr_idx_d = rxrb_pkg::advance(wr_idx_q);
            end
          end
          rxrb_pkg::KIND_POP: begin
            if (rd_idx_q != wr_idx_q) begin
              // store read issued now, data lands in S_POP
              rvalid_d   = 1'b1;
              rd_idx_d   = rxrb_pkg::advance(rd_idx_q);
              scan_idx_d = rxrb_pkg::advance(rd_idx_q);
              state_d    = S_POP;
            end
          end
          rxrb_pkg::KIND_CLEAR: begin
            rd_idx_d   = '0;
            wr_idx_d   = '0;
            scan_idx_d = '0;
            ovf_d      = 1'b0;
          end
          rxrb_pkg::KIND_OVERRUN: begin
            ovf_d = 1'b1;
          end
          default: begin
          end
        endcase
      end
      S_POP: begin
        rdata_d = mem_rdata_q;
        state_d = S_SCAN;
      end
      S_SCAN: begin
        // one read issued and one compare retired per cycle
        mem_raddr = scan_idx_q;
        if (ovf_q) begin
          len_d   = '0;
          state_d = S_PUT;
        end else if (pend_q && (mem_rdata_q == delim_i)) begin
          len_d   = n_q + rxrb_pkg::ADDR_W'(1);
          state_d = S_PUT;
        end else if (!pend_q && (scan_idx_q == wr_idx_q)) begin
          len_d   = '0;
          state_d = S_PUT;
        end else begin
          if (pend_q) begin
            n_d = n_q + rxrb_pkg::ADDR_W'(1);
          end
          if (scan_idx_q != wr_idx_q) begin
            scan_idx_d = rxrb_pkg::advance(scan_idx_q);
            pend_d     = 1'b1;
          end else begin
            pend_d = 1'b0;
          end
        end
      end
      S_PUT: begin
        res_valid_o = 1'b1;
        if (res_ready_i) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    if (wr_idx_q >= rd_idx_q) begin
      held = {1'b0, wr_idx_q} - {1'b0, rd_idx_q};
    end else begin
      held = rxrb_pkg::CNT_W'(rxrb_pkg::DEPTH) - {1'b0, rd_idx_q} + {1'b0, wr_idx_q};
    end
  end

  assign idle_o                = (state_q == S_IDLE);
  assign res_o.read_data       = rdata_q;
  assign res_o.read_valid      = rvalid_q;
  assign res_o.bytes_waiting   = rxrb_pkg::sat8(held);
  assign res_o.line_length     = rxrb_pkg::sat8({1'b0, len_q});
  assign res_o.overflow        = ovf_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      rd_idx_q <= '0;
      wr_idx_q <= '0;
      ovf_q    <= 1'b0;
      pend_q   <= 1'b0;
    end else begin
      state_q  <= state_d;
      rd_idx_q <= rd_idx_d;
      wr_idx_q <= wr_idx_d;
      ovf_q    <= ovf_d;
      pend_q   <= pend_d;
    end
  end

  always_ff @(posedge clk_i) begin
    scan_idx_q <= scan_idx_d;
    n_q        <= n_d;
    len_q      <= len_d;
    kind_q     <= kind_d;
    byte_q     <= byte_d;
    rdata_q    <= rdata_d;
    rvalid_q   <= rvalid_d;
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[wr_idx_q] <= byte_q;
    end
    mem_rdata_q <= mem_q[mem_raddr];
  end

  a_rvalid_only_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.read_valid |-> kind_q == rxrb_pkg::KIND_POP)
    else $error("read_valid without a pop");

  a_ovf_no_line: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.overflow |-> res_o.line_length == 8'd0)
    else $error("line length reported while overflow set");

  a_line_le_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> res_o.line_length <= res_o.bytes_waiting)
    else $error("line longer than bytes held");

  a_clear_empties: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_EXEC && kind_q == rxrb_pkg::KIND_CLEAR
      |=> rd_idx_q == wr_idx_q && !ovf_q)
    else $error("clear left bytes or overflow");

  a_scan_in_ring: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_SCAN |=> $stable(wr_idx_q) && $stable(rd_idx_q))
    else $error("pointers moved during scan");

endmodule

>>> rtl/core/rx_ring_buffer_line_detect_unit.sv
// Top level of the receive ring buffer with line delimiter detection.
//
//  port      dir   handshake      payload
//  in_i      sink  valid/ready    kind, rx_byte
//  out_o     src   valid/ready    read_data, read_valid, bytes_waiting,
//                                 line_length, overflow
//  cfg_*     in    write enable   line delimiter byte
//
// An item with an empty ring or overflow set ends without a compare; else the scan
// compares byte by byte: through the first delimiter, or every byte held when none
// matches; the scan reads the byte store once per cycle.
// A pop that finds a byte passes through S_POP for the store read.
// No new item is taken until the previous one has reached the output register;
// while a result waits there, the next item runs its scan and holds in its last state.
// Reset empties the ring, clears overflow and sets the delimiter to newline.
module rx_ring_buffer_line_detect_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  rxrb_in_if.sink           in_i,
  rxrb_out_if.source        out_o,
  input  logic              cfg_we_i,
  input  logic [7:0]        cfg_wdata_i
);

  logic [7:0]           delim_val_q;
  logic                 core_idle;
  logic                 res_valid;
  logic                 res_ready;
  rxrb_pkg::res_t       res;
  rxrb_pkg::res_t       res_q;
  logic                 out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      delim_val_q <= rxrb_pkg::DELIM_RST;
    end else if (cfg_we_i) begin
      delim_val_q <= cfg_wdata_i;
    end
  end

  assign in_i.ready = core_idle;
  assign res_ready  = !out_valid_q || out_o.ready;

  rxrb_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (in_i.valid && core_idle),
    .kind_i      (in_i.kind),
    .rx_byte_i   (in_i.rx_byte),
    .delim_i     (delim_val_q),
    .res_ready_i (res_ready),
    .idle_o      (core_idle),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  // output register: holds a result until its transfer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_valid && res_ready) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_valid && res_ready) begin
      res_q <= res;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.read_data     = res_q.read_data;
  assign out_o.read_valid    = res_q.read_valid;
  assign out_o.bytes_waiting = res_q.bytes_waiting;
  assign out_o.line_length   = res_q.line_length;
  assign out_o.overflow      = res_q.overflow;

endmodule
